### rtl/phg_pkg.sv
// Shared types and constants for the PUCCH hopping and cyclic shift generator.
`timescale 1ns / 1ps
`default_nettype none
package phg_pkg;

    localparam int MAX_SLOTS_DEF    = 80;
    localparam int SYMBOLS_DEF      = 14;
    localparam int GOLD_NC          = 1600;
    localparam int GROUPS           = 30;
    // Reciprocal of GROUPS in Q15, exact for dividends below 1024
    localparam int RECIP_30         = 1093;
    localparam int RECIP_SHIFT      = 15;
    localparam int GOLD_LEN         = 31;
    localparam int ID_W             = 10;
    localparam int SLOT_W           = 7;
    localparam int MODE_W           = 2;
    localparam int SLOT_CMP_W       = 8;
    localparam int IDQ_W            = 6;
    localparam int FSS_W            = 5;
    localparam int REM_W            = 15;
    localparam int SYM_W            = 4;
    localparam int HOP_W            = 8;

    localparam logic [MODE_W-1:0] MODE_GROUP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SEQ   = 2'd2;

    // Classified request handed from the front to the back
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [IDQ_W-1:0]  idq;
        logic [FSS_W-1:0]  fss;
        logic [SLOT_W-1:0] ns;
        logic [MODE_W-1:0] mode;
    } t_req;

    // Queue status seen by either side
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage
`default_nettype wire

### rtl/phg_front.sv
// Front end: accepts requests, reduces the slot and splits the identity.
`timescale 1ns / 1ps
`default_nettype none
module phg_front #(
    parameter int MAX_SLOTS = phg_pkg::MAX_SLOTS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire  [phg_pkg::ID_W-1:0]     i_hopping_id,
    input  wire  [phg_pkg::SLOT_W-1:0]   i_slot_index,
    input  wire  [phg_pkg::MODE_W-1:0]   i_hopping_mode,
    input  phg_pkg::t_q_status           i_q_status,
    output logic                         o_push,
    output phg_pkg::t_req                o_req
);

    typedef enum logic [2:0] {
        F_IDLE   = 3'b001,
        F_REDUCE = 3'b010,
        F_PUSH   = 3'b100
    } t_fstate;

    t_fstate r_state, n_state;
    logic [phg_pkg::ID_W-1:0]   r_id;
    logic [phg_pkg::SLOT_W-1:0] r_ns, n_ns;
    logic [phg_pkg::MODE_W-1:0] r_mode;
    logic [20:0]                w_prod;
    logic [phg_pkg::IDQ_W-1:0]  w_idq;
    logic [phg_pkg::ID_W-1:0]   w_fss_full;
    logic                       w_ns_high;

    // Split id into id/30 and id%30 by reciprocal multiply
    assign w_prod     = 21'(r_id) * 21'(phg_pkg::RECIP_30);
    assign w_idq      = w_prod[20:phg_pkg::RECIP_SHIFT];
    assign w_fss_full = r_id - (phg_pkg::ID_W'(w_idq) * phg_pkg::ID_W'(phg_pkg::GROUPS));
    assign w_ns_high  = {1'b0, r_ns} >= phg_pkg::SLOT_CMP_W'(MAX_SLOTS);

    assign busy   = (r_state != F_IDLE);
    assign o_push = (r_state == F_PUSH) && !i_q_status.full;
    assign o_req  = '{id: r_id, idq: w_idq, fss: w_fss_full[phg_pkg::FSS_W-1:0],
                      ns: r_ns, mode: r_mode};

    // Advance the front state
    always_comb begin
        n_state = r_state;
        n_ns    = r_ns;
        unique case (r_state)
            F_IDLE: begin
                if (start) begin
                    n_state = F_REDUCE;
                    n_ns    = i_slot_index;
                end
            end
            F_REDUCE: begin
                if (w_ns_high) begin
                    n_ns = r_ns - phg_pkg::SLOT_W'(MAX_SLOTS);
                end else begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_q_status.full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the request payload
    always_ff @(posedge i_clk) begin
        r_ns <= n_ns;
        if (r_state == F_IDLE && start) begin
            r_id   <= i_hopping_id;
            r_mode <= i_hopping_mode;
        end
    end

endmodule
`default_nettype wire

### rtl/phg_queue.sv
// Two-entry queue of classified requests between front and back.
`timescale 1ns / 1ps
`default_nettype none
module phg_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  phg_pkg::t_req       i_req,
    input  wire                 i_pop,
    output phg_pkg::t_req       o_req,
    output phg_pkg::t_q_status  o_status
);

    phg_pkg::t_req r_mem [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;

    assign o_req           = r_mem[r_rd_ptr];
    assign o_status.full   = (r_count == 2'd2);
    assign o_status.empty  = (r_count == 2'd0);

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    // Store the request
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

endmodule
`default_nettype wire

### rtl/phg_back.sv
// Back end: runs the Gold sequences and emits one result per symbol.
`timescale 1ns / 1ps
`default_nettype none
module phg_back #(
    parameter int SYMBOLS_PER_SLOT = phg_pkg::SYMBOLS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  phg_pkg::t_req                i_req,
    input  phg_pkg::t_q_status           i_q_status,
    output logic                         o_pop,
    output logic                         o_valid,
    output logic [phg_pkg::SYM_W-1:0]    o_symbol_index,
    output logic [phg_pkg::HOP_W-1:0]    o_shift_hop_value,
    output logic [phg_pkg::FSS_W-1:0]    o_group_first_hop,
    output logic                         o_seq_first_hop,
    output logic [phg_pkg::FSS_W-1:0]    o_group_second_hop,
    output logic                         o_seq_second_hop,
    output logic                         o_last
);

    localparam int L = phg_pkg::GOLD_LEN;
    localparam int RW = phg_pkg::REM_W;

    typedef enum logic [5:0] {
        B_IDLE = 6'b000001,
        B_GH   = 6'b000010,
        B_MOD  = 6'b000100,
        B_SH   = 6'b001000,
        B_CS   = 6'b010000,
        B_EMIT = 6'b100000
    } t_bstate;

    t_bstate r_state, n_state;
    phg_pkg::t_req r_req;
    logic [L-1:0]    r_x1, r_x2, n_x1, n_x2;
    logic [RW-1:0]   r_rem, n_rem;
    logic [2*L-1:0]  w_w1, w_w2;
    logic [L-1:0]    w_c;
    logic [RW-1:0]   w_step;
    logic [phg_pkg::SYM_W-1:0] r_sym;
    logic [8:0]      r_sum0, r_sum1;
    logic [phg_pkg::FSS_W-1:0] r_u0, r_u1;
    logic            r_v0, r_v1;
    logic [18:0]     w_p0, w_p1;
    logic [8:0]      w_r0, w_r1;
    logic            w_pos;
    logic            w_load;
    logic [L-1:0]    w_seed;
    logic [RW-1:0]   w_skip;
    logic            w_emit_last;

    // Extend both registers by one full block of future bits
    always_comb begin
        w_w1 = {{L{1'b0}}, r_x1};
        w_w2 = {{L{1'b0}}, r_x2};
        for (int k = 0; k < L; k++) begin
            w_w1[L+k] = w_w1[k+3] ^ w_w1[k];
            w_w2[L+k] = w_w2[k+3] ^ w_w2[k+2] ^ w_w2[k+1] ^ w_w2[k];
        end
    end

    assign w_c = r_x1 ^ r_x2;
    // Still positioning: step by a block, a byte or a bit
    assign w_pos = (r_rem != '0);
    always_comb begin
        priority if (r_rem >= RW'(L)) begin
            w_step = RW'(L);
        end else if (r_rem >= RW'(8)) begin
            w_step = RW'(8);
        end else if (w_pos) begin
            w_step = RW'(1);
        end else begin
            w_step = '0;
        end
    end

    // Group sum mod 30 by reciprocal multiply
    assign w_p0 = 19'(r_sum0) * 19'(phg_pkg::RECIP_30);
    assign w_p1 = 19'(r_sum1) * 19'(phg_pkg::RECIP_30);
    assign w_r0 = r_sum0 - 9'(9'(w_p0[18:phg_pkg::RECIP_SHIFT]) * 9'(phg_pkg::GROUPS));
    assign w_r1 = r_sum1 - 9'(9'(w_p1[18:phg_pkg::RECIP_SHIFT]) * 9'(phg_pkg::GROUPS));

    assign w_emit_last = (r_sym == phg_pkg::SYM_W'(SYMBOLS_PER_SLOT - 1));
    assign o_pop = (r_state == B_IDLE) && !i_q_status.empty;

    // Sequence control
    always_comb begin
        n_state = r_state;
        w_load  = 1'b0;
        w_seed  = '0;
        w_skip  = '0;
        unique case (r_state)
            B_IDLE: begin
                if (!i_q_status.empty) begin
                    w_load = 1'b1;
                    priority if (i_req.mode == phg_pkg::MODE_GROUP) begin
                        n_state = B_GH;
                        w_seed  = L'(i_req.idq);
                        w_skip  = RW'(phg_pkg::GOLD_NC) + RW'({i_req.ns, 4'b0000});
                    end else if (i_req.mode == phg_pkg::MODE_SEQ) begin
                        n_state = B_SH;
                        w_seed  = L'({i_req.idq, i_req.fss});
                        w_skip  = RW'(phg_pkg::GOLD_NC) + RW'({i_req.ns, 1'b0});
                    end else begin
                        n_state = B_CS;
                        w_seed  = L'(i_req.id);
                        w_skip  = RW'(phg_pkg::GOLD_NC)
                                + RW'(i_req.ns) * RW'(8 * SYMBOLS_PER_SLOT);
                    end
                end
            end
            B_GH: begin
                if (!w_pos) begin
                    n_state = B_MOD;
                end
            end
            B_MOD, B_SH: begin
                if (r_state == B_MOD || !w_pos) begin
                    n_state = B_CS;
                    w_load  = 1'b1;
                    w_seed  = L'(r_req.id);
                    w_skip  = RW'(phg_pkg::GOLD_NC)
                            + RW'(r_req.ns) * RW'(8 * SYMBOLS_PER_SLOT);
                end
            end
            B_CS: begin
                if (!w_pos) begin
                    n_state = B_EMIT;
                end
            end
            B_EMIT: begin
                if (w_emit_last) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // Load a seed or advance the generators
    always_comb begin
        if (w_load) begin
            n_x1  = L'(1);
            n_x2  = w_seed;
            n_rem = w_skip;
        end else if (r_state == B_EMIT) begin
            n_x1  = w_w1[8 +: L];
            n_x2  = w_w2[8 +: L];
            n_rem = r_rem;
        end else begin
            unique case (w_step)
                RW'(L): begin
                    n_x1 = w_w1[L +: L];
                    n_x2 = w_w2[L +: L];
                end
                RW'(8): begin
                    n_x1 = w_w1[8 +: L];
                    n_x2 = w_w2[8 +: L];
                end
                RW'(1): begin
                    n_x1 = w_w1[1 +: L];
                    n_x2 = w_w2[1 +: L];
                end
                default: begin
                    n_x1 = r_x1;
                    n_x2 = r_x2;
                end
            endcase
            n_rem = r_rem - w_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= (r_state == B_EMIT);
        end
    end

    // Hold sequence state, hop values and results
    always_ff @(posedge i_clk) begin
        r_x1  <= n_x1;
        r_x2  <= n_x2;
        r_rem <= n_rem;
        if (o_pop) begin
            r_req <= i_req;
            r_u0  <= i_req.fss;
            r_u1  <= i_req.fss;
            r_v0  <= 1'b0;
            r_v1  <= 1'b0;
            r_sym <= '0;
        end
        if (r_state == B_GH && !w_pos) begin
            r_sum0 <= 9'(r_req.fss) + 9'(w_c[7:0]);
            r_sum1 <= 9'(r_req.fss) + 9'(w_c[15:8]);
        end
        if (r_state == B_MOD) begin
            r_u0 <= w_r0[phg_pkg::FSS_W-1:0];
            r_u1 <= w_r1[phg_pkg::FSS_W-1:0];
        end
        if (r_state == B_SH && !w_pos) begin
            r_v0 <= w_c[0];
            r_v1 <= w_c[1];
        end
        if (r_state == B_EMIT) begin
            r_sym              <= r_sym + phg_pkg::SYM_W'(1);
            o_symbol_index     <= r_sym;
            o_shift_hop_value  <= w_c[7:0];
            o_group_first_hop  <= r_u0;
            o_seq_first_hop    <= r_v0;
            o_group_second_hop <= r_u1;
            o_seq_second_hop   <= r_v1;
            o_last             <= w_emit_last;
        end
    end

endmodule
`default_nettype wire

### rtl/pucch_hopping_and_cyclic_shift_gen.sv
// Top level of the PUCCH group/sequence and cyclic shift hopping generator.
//
// Usage:
//   A request (hopping id, slot index, hopping mode) is taken at a rising
//   edge where start is high and busy is low. The front reduces the slot
//   modulo MAX_SLOTS and queues the request in a two-entry queue, so a new
//   request can be taken while the back works. The back runs the Gold
//   generators in steps of 31, 8 or 1 bits to each start position: group
//   hopping (mode 1) or sequence hopping (mode 2) first, then cyclic shift,
//   which other modes run alone. It then emits SYMBOLS_PER_SLOT results on
//   consecutive cycles, each marked by o_valid for one cycle, with o_last on
//   the final one. Time from request to first result grows with the slot
//   index and with the hopping sequence walk in modes 1 and 2; the sustained
//   rate is set by the back's generator walk and depends on slot and mode.
//   The receiver cannot stall: results are produced as they are ready.
//   Reset (i_rst_n low, synchronous) empties the queue and idles both parts.
`timescale 1ns / 1ps
`default_nettype none
module pucch_hopping_and_cyclic_shift_gen #(
    parameter int MAX_SLOTS        = phg_pkg::MAX_SLOTS_DEF,
    parameter int SYMBOLS_PER_SLOT = phg_pkg::SYMBOLS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire  [phg_pkg::ID_W-1:0]     i_hopping_id,
    input  wire  [phg_pkg::SLOT_W-1:0]   i_slot_index,
    input  wire  [phg_pkg::MODE_W-1:0]   i_hopping_mode,
    output logic                         o_valid,
    output logic [phg_pkg::SYM_W-1:0]    o_symbol_index,
    output logic [phg_pkg::HOP_W-1:0]    o_shift_hop_value,
    output logic [phg_pkg::FSS_W-1:0]    o_group_first_hop,
    output logic                         o_seq_first_hop,
    output logic [phg_pkg::FSS_W-1:0]    o_group_second_hop,
    output logic                         o_seq_second_hop,
    output logic                         o_last
);

    phg_pkg::t_req      w_push_req;
    phg_pkg::t_req      w_head_req;
    phg_pkg::t_q_status w_q_status;
    logic               w_push;
    logic               w_pop;

    phg_front #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_hopping_id   (i_hopping_id),
        .i_slot_index   (i_slot_index),
        .i_hopping_mode (i_hopping_mode),
        .i_q_status     (w_q_status),
        .o_push         (w_push),
        .o_req          (w_push_req)
    );

    phg_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_req    (w_push_req),
        .i_pop    (w_pop),
        .o_req    (w_head_req),
        .o_status (w_q_status)
    );

    phg_back #(
        .SYMBOLS_PER_SLOT (SYMBOLS_PER_SLOT)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_req              (w_head_req),
        .i_q_status         (w_q_status),
        .o_pop              (w_pop),
        .o_valid            (o_valid),
        .o_symbol_index     (o_symbol_index),
        .o_shift_hop_value  (o_shift_hop_value),
        .o_group_first_hop  (o_group_first_hop),
        .o_seq_first_hop    (o_seq_first_hop),
        .o_group_second_hop (o_group_second_hop),
        .o_seq_second_hop   (o_seq_second_hop),
        .o_last             (o_last)
    );

endmodule
`default_nettype wire
